>>> hw/rtl/ses_pkg.sv
// Shared constants, codes and word types of the sorted set engine.
package ses_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int COUNT_W  = 7;
  localparam int DATA_W   = 32;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_MEMBER = 3'd2;
  localparam logic [2:0] OP_MIN    = 3'd3;
  localparam logic [2:0] OP_MAX    = 3'd4;
  localparam logic [2:0] OP_XMIN   = 3'd5;
  localparam logic [2:0] OP_XMAX   = 3'd6;
  localparam logic [2:0] OP_CLEAR  = 3'd7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] result_value;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
  } out_word_t;

endpackage

>>> hw/rtl/ses_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ses_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/sorted_set_engine_core.sv
// Sorted set engine: binary search and one-cell-per-cycle shift over a single RAM.
//
//   channel | ports                      | word
//   --------+----------------------------+-----------------------------
//   input   | in_valid, in_stall, in_data | func, value
//   output  | out_valid, out_stall, out_data | status, result_value, count, is_empty
//
// One request at a time.
// Member runs a binary search; each step waits for the registered read data of the store.
// Add and remove follow the search with a shift: one cell moves per cycle through
// the store's read and write ports.
// Min, max and extract_max read one cell, and extract_max drops the count; extract_min
// reads the first cell and then shifts the rest down; clear only resets the count.
// Reset empties the set at once; a waiting result does not block the next request.
module sorted_set_engine_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ses_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ses_pkg::out_word_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_SCMP = 3'd2;
  localparam logic [2:0] S_SDEC = 3'd3;
  localparam logic [2:0] S_SHUP = 3'd4;
  localparam logic [2:0] S_SHDN = 3'd5;
  localparam logic [2:0] S_RDX  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]                        state_r, state_nxt;
  logic [ses_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic [2:0]                        func_r, func_nxt;
  logic signed [ses_pkg::DATA_W-1:0] value_r, value_nxt;
  logic [ses_pkg::CNT_W-1:0]         lo_r, lo_nxt;
  logic [ses_pkg::CNT_W-1:0]         hi_r, hi_nxt;
  logic [ses_pkg::CNT_W-1:0]         mid_r, mid_nxt;
  logic                              found_r, found_nxt;
  logic [ses_pkg::CNT_W-1:0]         pos_r, pos_nxt;
  logic [ses_pkg::CNT_W-1:0]         ptr_r, ptr_nxt;
  logic                              pend_r, pend_nxt;
  logic [ses_pkg::CNT_W-1:0]         waddr_r, waddr_nxt;
  logic [1:0]                        status_r, status_nxt;
  logic signed [ses_pkg::DATA_W-1:0] rv_r, rv_nxt;
  logic                              out_valid_r, out_valid_nxt;
  ses_pkg::out_word_t                out_data_r, out_data_nxt;

  logic                              ram_we;
  logic [ses_pkg::IDX_W-1:0]         ram_waddr;
  logic [ses_pkg::DATA_W-1:0]        ram_wdata;
  logic                              ram_re;
  logic [ses_pkg::IDX_W-1:0]         ram_raddr;
  logic signed [ses_pkg::DATA_W-1:0] ram_rdata;

  logic [ses_pkg::CNT_W:0]           mid_sum;
  logic [ses_pkg::CNT_W-1:0]         cnt_m1;
  logic [ses_pkg::CNT_W-1:0]         cnt_p1;
  logic [ses_pkg::CNT_W-1:0]         ptr_m1;
  logic [ses_pkg::CNT_W-1:0]         ptr_p1;
  logic [ses_pkg::CNT_W-1:0]         mid_p1;
  logic [ses_pkg::CNT_W-1:0]         pos_p1;

  ses_ram #(
    .WIDTH(ses_pkg::DATA_W),
    .DEPTH(ses_pkg::CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign cnt_m1  = count_r - ses_pkg::CNT_W'(1);
  assign cnt_p1  = count_r + ses_pkg::CNT_W'(1);
  assign ptr_m1  = ptr_r - ses_pkg::CNT_W'(1);
  assign ptr_p1  = ptr_r + ses_pkg::CNT_W'(1);
  assign mid_p1  = mid_r + ses_pkg::CNT_W'(1);
  assign pos_p1  = pos_r + ses_pkg::CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    func_nxt      = func_r;
    value_nxt     = value_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = pend_r;
    waddr_nxt     = waddr_r;
    status_nxt    = status_r;
    rv_nxt        = rv_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_data.func;
          value_nxt  = in_data.value;
          status_nxt = ses_pkg::ST_OK;
          rv_nxt     = '0;
          lo_nxt     = '0;
          hi_nxt     = count_r;
          found_nxt  = 1'b0;
          if (in_data.func inside {ses_pkg::OP_ADD, ses_pkg::OP_REMOVE,
                                   ses_pkg::OP_MEMBER}) begin
            state_nxt = S_SRCH;
          end else if (in_data.func == ses_pkg::OP_CLEAR) begin
            count_nxt = '0;
            state_nxt = S_DONE;
          end else if (count_r == '0) begin
            status_nxt = ses_pkg::ST_FAIL;
            state_nxt  = S_DONE;
          end else begin
            ram_re = 1'b1;
            if (in_data.func inside {ses_pkg::OP_MAX, ses_pkg::OP_XMAX}) begin
              ram_raddr = cnt_m1[ses_pkg::IDX_W-1:0];
            end
            state_nxt = S_RDX;
          end
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_sum[ses_pkg::CNT_W:1];
          ram_re    = 1'b1;
          ram_raddr = mid_nxt[ses_pkg::IDX_W-1:0];
          state_nxt = S_SCMP;
        end else begin
          pos_nxt   = lo_r;
          state_nxt = S_SDEC;
        end
      end
      S_SCMP: begin
        if (ram_rdata == value_r) begin
          found_nxt = 1'b1;
          pos_nxt   = mid_r;
          state_nxt = S_SDEC;
        end else begin
          if (ram_rdata < value_r) begin
            lo_nxt = mid_p1;
          end else begin
            hi_nxt = mid_r;
          end
          state_nxt = S_SRCH;
        end
      end
      S_SDEC: begin
        pend_nxt  = 1'b0;
        state_nxt = S_DONE;
        case (func_r)
          ses_pkg::OP_ADD: begin
            if (found_r) begin
              status_nxt = ses_pkg::ST_FAIL;
            end else if (count_r == ses_pkg::CAP_CNT) begin
              status_nxt = ses_pkg::ST_FULL;
            end else begin
              ptr_nxt   = count_r;
              state_nxt = S_SHUP;
            end
          end
          ses_pkg::OP_REMOVE: begin
            if (found_r) begin
              ptr_nxt   = pos_p1;
              state_nxt = S_SHDN;
            end else begin
              status_nxt = ses_pkg::ST_FAIL;
            end
          end
          default: begin
            if (!found_r) begin
              status_nxt = ses_pkg::ST_FAIL;
            end
          end
        endcase
      end
      S_SHUP: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = waddr_r[ses_pkg::IDX_W-1:0];
        end
        if (ptr_r > pos_r) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_m1[ses_pkg::IDX_W-1:0];
          waddr_nxt = ptr_r;
          ptr_nxt   = ptr_m1;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            ram_we    = 1'b1;
            ram_waddr = pos_r[ses_pkg::IDX_W-1:0];
            ram_wdata = value_r;
            count_nxt = cnt_p1;
            state_nxt = S_DONE;
          end
        end
      end
      S_SHDN: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = waddr_r[ses_pkg::IDX_W-1:0];
        end
        if (ptr_r < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_r[ses_pkg::IDX_W-1:0];
          waddr_nxt = ptr_m1;
          ptr_nxt   = ptr_p1;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = cnt_m1;
            state_nxt = S_DONE;
          end
        end
      end
      S_RDX: begin
        rv_nxt    = ram_rdata;
        pend_nxt  = 1'b0;
        state_nxt = S_DONE;
        if (func_r == ses_pkg::OP_XMIN) begin
          ptr_nxt   = ses_pkg::CNT_W'(1);
          state_nxt = S_SHDN;
        end else if (func_r == ses_pkg::OP_XMAX) begin
          count_nxt = cnt_m1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = status_r;
          out_data_nxt.result_value = rv_r;
          out_data_nxt.count        = ses_pkg::COUNT_W'(count_r);
          out_data_nxt.is_empty     = (count_r == '0);
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    value_r    <= value_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    found_r    <= found_nxt;
    pos_r      <= pos_nxt;
    ptr_r      <= ptr_nxt;
    waddr_r    <= waddr_nxt;
    status_r   <= status_nxt;
    rv_r       <= rv_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ses_pkg::CAP_CNT)
    else $error("element count above capacity");

  a_write_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SHUP || state_r == S_SHDN))
    else $error("store written outside a shift");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("engine idle right after taking a word");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word raised outside completion");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHUP) |-> (count_r < ses_pkg::CAP_CNT))
    else $error("insert shift into a full store");
`endif

endmodule

>>> verif/sorted_set_engine_core_tb.sv
// Self-checking testbench for the sorted set engine: queued stimulus, cycle monitor, scoreboard.
module sorted_set_engine_core_tb;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  localparam int WATCH_LIMIT = 5000;
  localparam int PHASE_ITEMS = 256;
  localparam int POOL_DEPTH  = 96;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  ses_pkg::in_word_t  in_data   = '0;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ses_pkg::out_word_t out_data;

  ses_pkg::in_word_t                 req_q[$];
  ses_pkg::out_word_t                resp_due_q[$];
  logic signed [ses_pkg::DATA_W-1:0] value_pool[$];

  logic signed [ses_pkg::DATA_W-1:0] set_cells[ses_pkg::CAPACITY];
  int                                set_size = 0;

  idle_mode_t         idle_mode = IDLE_NONE;
  bit                 word_taken = 1'b0;
  int                 quiet_cycles = 0;
  int                 errors = 0;
  int                 words_in = 0;
  int                 words_out = 0;
  int                 full_rejects = 0;
  int                 fail_answers = 0;
  int                 peak_size = 0;
  int                 pushed = 0;
  ses_pkg::out_word_t predicted;

  sorted_set_engine_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic set_apply(input ses_pkg::in_word_t w, output ses_pkg::out_word_t r);
    logic signed [ses_pkg::DATA_W-1:0] v;
    int  pos;
    int  i;
    logic hit;
    v = w.value;
    r = '0;
    r.status = ses_pkg::ST_OK;
    pos = 0;
    while (pos < set_size && set_cells[pos] < v) pos++;
    hit = (pos < set_size) && (set_cells[pos] == v);
    case (w.func)
      ses_pkg::OP_ADD: begin
        if (hit) begin
          r.status = ses_pkg::ST_FAIL;
        end else if (set_size >= ses_pkg::CAPACITY) begin
          r.status = ses_pkg::ST_FULL;
        end else begin
          for (i = set_size; i > pos; i--) set_cells[i] = set_cells[i-1];
          set_cells[pos] = v;
          set_size++;
        end
      end
      ses_pkg::OP_REMOVE: begin
        if (hit) begin
          for (i = pos; i < set_size - 1; i++) set_cells[i] = set_cells[i+1];
          set_size--;
        end else begin
          r.status = ses_pkg::ST_FAIL;
        end
      end
      ses_pkg::OP_MEMBER: begin
        if (!hit) r.status = ses_pkg::ST_FAIL;
      end
      ses_pkg::OP_MIN, ses_pkg::OP_XMIN: begin
        if (set_size == 0) begin
          r.status = ses_pkg::ST_FAIL;
        end else begin
          r.result_value = set_cells[0];
          if (w.func == ses_pkg::OP_XMIN) begin
            for (i = 0; i < set_size - 1; i++) set_cells[i] = set_cells[i+1];
            set_size--;
          end
        end
      end
      ses_pkg::OP_MAX, ses_pkg::OP_XMAX: begin
        if (set_size == 0) begin
          r.status = ses_pkg::ST_FAIL;
        end else begin
          r.result_value = set_cells[set_size-1];
          if (w.func == ses_pkg::OP_XMAX) set_size--;
        end
      end
      default: begin
        set_size = 0;
      end
    endcase
    r.count    = ses_pkg::COUNT_W'(set_size);
    r.is_empty = (set_size == 0);
    if (r.status == ses_pkg::ST_FULL) full_rejects++;
    if (r.status == ses_pkg::ST_FAIL) fail_answers++;
    if (set_size > peak_size) peak_size = set_size;
  endtask

  task automatic check_field(input string name, input logic [ses_pkg::DATA_W-1:0] want,
                             input logic [ses_pkg::DATA_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // sample both channels, score results, track progress
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      words_out++;
      if (resp_due_q.size() == 0) begin
        errors++;
        $display("%0t: result word expected none got %0h", $time, out_data);
      end else begin
        predicted = resp_due_q.pop_front();
        check_field("status", ses_pkg::DATA_W'(predicted.status),
                    ses_pkg::DATA_W'(out_data.status));
        check_field("result_value", predicted.result_value, out_data.result_value);
        check_field("count", ses_pkg::DATA_W'(predicted.count),
                    ses_pkg::DATA_W'(out_data.count));
        check_field("is_empty", ses_pkg::DATA_W'(predicted.is_empty),
                    ses_pkg::DATA_W'(out_data.is_empty));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      words_in++;
      set_apply(in_data, predicted);
      resp_due_q.push_back(predicted);
      word_taken = 1'b1;
    end
    if ((rst_n && out_valid && !out_stall) || (rst_n && in_valid && !in_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  // drive request words and result stall
  always @(negedge clk) begin : drive_side
    bit rest_in;
    bit rest_out;
    rest_in  = (idle_mode == IDLE_SEND && $urandom_range(99) < 65) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < 30);
    rest_out = (idle_mode == IDLE_RECV && $urandom_range(99) < 65) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < 30);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      word_taken = 1'b0;
      if (req_q.size() != 0 && !rest_in) begin
        in_data  <= req_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rest_out;
  end

  task automatic push_request(input logic [2:0] f,
                              input logic signed [ses_pkg::DATA_W-1:0] v);
    ses_pkg::in_word_t w;
    w.func  = f;
    w.value = v;
    req_q.push_back(w);
    pushed++;
    if (f == ses_pkg::OP_ADD) begin
      value_pool.push_back(v);
      if (value_pool.size() > POOL_DEPTH) void'(value_pool.pop_front());
    end
  endtask

  function automatic logic signed [ses_pkg::DATA_W-1:0] pick_value();
    int k;
    k = $urandom_range(99);
    if (k < 45 && value_pool.size() != 0)
      return value_pool[$urandom_range(value_pool.size() - 1)];
    if (k < 70)
      return int'($urandom_range(40)) - 20;
    if (k < 76) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom();
  endfunction

  // one random sequence: fill, drain, mixed traffic, clear or noise
  task automatic push_random_burst();
    int kind;
    int n;
    int i;
    kind = $urandom_range(99);
    if (kind < 35) begin
      n = (kind < 8) ? 72 : $urandom_range(40, 4);
      for (i = 0; i < n; i++)
        push_request(ses_pkg::OP_ADD,
                     ($urandom_range(7) == 0) ? pick_value() : $urandom());
    end else if (kind < 55) begin
      n = $urandom_range(20, 3);
      for (i = 0; i < n; i++) begin
        case ($urandom_range(4))
          0:       push_request(ses_pkg::OP_XMIN, $urandom());
          1:       push_request(ses_pkg::OP_XMAX, $urandom());
          2:       push_request(ses_pkg::OP_MIN, $urandom());
          3:       push_request(ses_pkg::OP_MAX, $urandom());
          default: push_request(ses_pkg::OP_REMOVE, pick_value());
        endcase
      end
    end else if (kind < 92) begin
      n = $urandom_range(20, 3);
      for (i = 0; i < n; i++) push_request(3'($urandom_range(6)), pick_value());
    end else if (kind < 96) begin
      push_request(ses_pkg::OP_CLEAR, $urandom());
    end else begin
      n = $urandom_range(5, 1);
      for (i = 0; i < n; i++) push_request(3'($urandom_range(7)), $urandom());
    end
  endtask

  initial begin : stimulus
    int ph;
    int goal;
    push_request(ses_pkg::OP_MIN, 0);
    push_request(ses_pkg::OP_MAX, 0);
    push_request(ses_pkg::OP_XMIN, 0);
    push_request(ses_pkg::OP_XMAX, 0);
    push_request(ses_pkg::OP_REMOVE, 5);
    push_request(ses_pkg::OP_MEMBER, 5);
    push_request(ses_pkg::OP_ADD, 0);
    push_request(ses_pkg::OP_ADD, 32'h8000_0000);
    push_request(ses_pkg::OP_ADD, 32'h7FFF_FFFF);
    push_request(ses_pkg::OP_ADD, 0);
    push_request(ses_pkg::OP_ADD, 32'hFFFF_FFFF);
    push_request(ses_pkg::OP_ADD, 32'h5555_5555);
    push_request(ses_pkg::OP_ADD, 32'hAAAA_AAAA);
    push_request(ses_pkg::OP_MEMBER, 32'h8000_0000);
    push_request(ses_pkg::OP_MEMBER, 1);
    push_request(ses_pkg::OP_MIN, 0);
    push_request(ses_pkg::OP_MAX, 0);
    push_request(ses_pkg::OP_REMOVE, 32'h7FFF_FFFF);
    push_request(ses_pkg::OP_REMOVE, 7);
    push_request(ses_pkg::OP_XMIN, 0);
    push_request(ses_pkg::OP_XMAX, 0);
    push_request(ses_pkg::OP_CLEAR, 32'hFFFF_FFFF);
    push_request(ses_pkg::OP_MIN, 0);
    push_request(ses_pkg::OP_CLEAR, 0);
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    for (ph = 0; ph < 4; ph++) begin
      while (req_q.size() != 0) @(posedge clk);
      idle_mode = idle_mode_t'(ph);
      goal = pushed + PHASE_ITEMS;
      while (pushed < goal) push_random_burst();
    end
    while (req_q.size() != 0 || in_valid || resp_due_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("Covered %0d requests and %0d results over four idle/stall mixes.",
             words_in, words_out);
    $display("Set peaked at %0d of %0d; %0d full rejects, %0d duplicate/absent/empty.",
             peak_size, ses_pkg::CAPACITY, full_rejects, fail_answers);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    while (quiet_cycles < WATCH_LIMIT) @(negedge clk);
    $display("%0t: no word moved for %0d cycles", $time, WATCH_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
